[rtl/arlp_pkg.sv]
// Shared types, character codes and prefixes of the AT response line parser.
package arlp_pkg;

    // Line buffer sizes
    localparam int              HEAD_DEPTH = 17;
    localparam logic [7:0]      LINE_MAX   = 8'd128;
    localparam logic [7:0]      MIN_LINE   = 8'd2;

    // Character codes
    localparam logic [7:0]      CHR_CR     = 8'h0D;
    localparam logic [7:0]      CHR_LF     = 8'h0A;
    localparam logic [7:0]      CHR_0      = 8'h30;
    localparam logic [7:0]      CHR_9      = 8'h39;

    // Response prefixes, first character at index 0
    localparam logic [0:10][7:0] PFX_SIM   = "+QSIMSTAT: ";
    localparam logic [0:5][7:0]  PFX_CSQ   = "+CSQ: ";
    localparam logic [0:15][7:0] PFX_NET   = "+QNETDEVSTATUS: ";

    // Field positions
    localparam logic [7:0]      NUM_POS     = 8'd6;
    localparam int              SIM_POS     = 13;
    localparam int              NET_POS     = 16;
    localparam logic [7:0]      LEN_SIM     = 8'd11;
    localparam logic [7:0]      LEN_CSQ     = 8'd6;
    localparam logic [7:0]      LEN_NET     = 8'd16;
    localparam logic [7:0]      LEN_SIM_DIG = 8'd14;
    localparam logic [7:0]      LEN_NET_DIG = 8'd17;

    // Number parser phases
    localparam logic [1:0]      PH_WAIT    = 2'd0;
    localparam logic [1:0]      PH_RUN     = 2'd1;
    localparam logic [1:0]      PH_DONE    = 2'd2;
    localparam logic [1:0]      PH_NONE    = 2'd3;

    // Line kinds
    localparam logic [1:0]      KIND_OTHER = 2'd0;
    localparam logic [1:0]      KIND_SIM   = 2'd1;
    localparam logic [1:0]      KIND_CSQ   = 2'd2;
    localparam logic [1:0]      KIND_NET   = 2'd3;

    typedef struct packed {
        logic [0:HEAD_DEPTH-1][7:0] head;
        logic [7:0]                 len;
        logic [1:0]                 phase;
        logic [7:0]                 accum;
    } line_st_t;

    typedef struct packed {
        logic     fire;
        line_st_t line;
    } line_evt_t;

    typedef struct packed {
        logic [1:0] line_kind;
        logic [3:0] sim_now;
        logic [3:0] net_now;
        logic [7:0] signal_now;
        logic       sim_removed;
        logic       signal_report;
    } rsp_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHR_0) && (c <= CHR_9);
    endfunction

endpackage

[rtl/arlp_in_if.sv]
// Byte request channel into the parser.
interface arlp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

[rtl/arlp_out_if.sv]
// Decoded line request channel out of the parser.
interface arlp_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] line_kind;
    logic [3:0] sim_now;
    logic [3:0] net_now;
    logic [7:0] signal_now;
    logic       sim_removed;
    logic       signal_report;

    modport source (output valid, output line_kind, output sim_now, output net_now,
                    output signal_now, output sim_removed, output signal_report,
                    input ready);
    modport sink   (input valid, input line_kind, input sim_now, input net_now,
                    input signal_now, input sim_removed, input signal_report,
                    output ready);
endinterface

[rtl/arlp_line_split.sv]
// Input byte register and CR LF line splitter with head and number capture.
module arlp_line_split (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic [7:0]          in_byte,
    output logic                in_ready,
    input  logic                advance,
    output arlp_pkg::line_evt_t evt
);

    logic                 byte_valid_reg;
    logic                 byte_valid_next;
    logic [7:0]           byte_reg;
    arlp_pkg::line_st_t   line_reg;
    arlp_pkg::line_st_t   line_next;
    logic                 cr_reg;
    logic                 cr_next;
    logic                 go;

    // Append one content character to the line state.
    function automatic arlp_pkg::line_st_t take_char(input arlp_pkg::line_st_t s,
                                                     input logic [7:0] c);
        arlp_pkg::line_st_t r;
        logic [11:0]        prod;
        r    = s;
        prod = 12'({4'd0, s.accum} * 12'd10) + {8'd0, c[3:0]};
        if (s.len < arlp_pkg::LINE_MAX)
        begin
            if (s.len < 8'(arlp_pkg::HEAD_DEPTH))
                r.head[s.len[4:0]] = c;
            if (s.len == arlp_pkg::NUM_POS)
            begin
                if (arlp_pkg::is_digit(c))
                begin
                    r.accum = {4'd0, c[3:0]};
                    r.phase = arlp_pkg::PH_RUN;
                end
                else
                begin
                    r.phase = arlp_pkg::PH_NONE;
                end
            end
            else if (s.len > arlp_pkg::NUM_POS && s.phase == arlp_pkg::PH_RUN)
            begin
                if (arlp_pkg::is_digit(c))
                    r.accum = (prod > 12'd255) ? 8'd255 : prod[7:0];
                else
                    r.phase = arlp_pkg::PH_DONE;
            end
            r.len = s.len + 8'd1;
        end
        return r;
    endfunction

    assign go       = byte_valid_reg && advance;
    assign in_ready = !byte_valid_reg || advance;

    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        if (in_valid && in_ready)
            byte_valid_next = 1'b1;
        else if (go)
            byte_valid_next = 1'b0;
    end

    always_comb
    begin
        line_next = line_reg;
        cr_next   = cr_reg;
        evt       = '0;
        if (go)
        begin
            if (cr_reg)
            begin
                if (byte_reg == arlp_pkg::CHR_LF)
                begin
                    evt.fire  = (line_reg.len >= arlp_pkg::MIN_LINE);
                    evt.line  = line_reg;
                    line_next = '0;
                    cr_next   = 1'b0;
                end
                else
                begin
                    // pending CR turns out to be content
                    line_next = take_char(line_reg, arlp_pkg::CHR_CR);
                    if (byte_reg != arlp_pkg::CHR_CR)
                    begin
                        cr_next   = 1'b0;
                        line_next = take_char(line_next, byte_reg);
                    end
                end
            end
            else if (byte_reg == arlp_pkg::CHR_CR)
            begin
                cr_next = 1'b1;
            end
            else
            begin
                line_next = take_char(line_reg, byte_reg);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            line_reg       <= '0;
            cr_reg         <= 1'b0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
            line_reg       <= line_next;
            cr_reg         <= cr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
            byte_reg <= in_byte;
    end

endmodule

[rtl/arlp_line_decode.sv]
// Prefix match, stored modem states and result register.
module arlp_line_decode (
    input  logic                clk,
    input  logic                rst_n,
    input  arlp_pkg::line_evt_t evt,
    input  logic                out_ready,
    output logic                out_valid,
    output arlp_pkg::rsp_t      rsp
);

    logic             valid_reg;
    logic             valid_next;
    arlp_pkg::rsp_t   rsp_reg;
    arlp_pkg::rsp_t   rsp_next;
    logic [3:0]       sim_reg;
    logic [3:0]       sim_next;
    logic [3:0]       net_reg;
    logic [3:0]       net_next;
    logic [7:0]       sig_reg;
    logic [7:0]       sig_next;
    logic [7:0]       sim_chr;
    logic [7:0]       net_chr;
    logic             removed;
    logic             report;
    logic [1:0]       kind;

    assign sim_chr = evt.line.head[arlp_pkg::SIM_POS];
    assign net_chr = evt.line.head[arlp_pkg::NET_POS];

    always_comb
    begin
        kind     = arlp_pkg::KIND_OTHER;
        removed  = 1'b0;
        report   = 1'b0;
        sim_next = sim_reg;
        net_next = net_reg;
        sig_next = sig_reg;
        if (evt.fire)
        begin
            if (evt.line.len >= arlp_pkg::LEN_SIM &&
                evt.line.head[0:10] == arlp_pkg::PFX_SIM)
            begin
                kind = arlp_pkg::KIND_SIM;
                if (evt.line.len >= arlp_pkg::LEN_SIM_DIG && arlp_pkg::is_digit(sim_chr) &&
                    sim_chr[3:0] != sim_reg)
                begin
                    removed  = (sim_chr[3:0] == 4'd0);
                    sim_next = sim_chr[3:0];
                end
            end
            else if (evt.line.len >= arlp_pkg::LEN_CSQ &&
                     evt.line.head[0:5] == arlp_pkg::PFX_CSQ)
            begin
                kind = arlp_pkg::KIND_CSQ;
                if (evt.line.phase == arlp_pkg::PH_RUN ||
                    evt.line.phase == arlp_pkg::PH_DONE)
                begin
                    sig_next = evt.line.accum;
                    report   = 1'b1;
                end
            end
            else if (evt.line.len >= arlp_pkg::LEN_NET &&
                     evt.line.head[0:15] == arlp_pkg::PFX_NET)
            begin
                kind = arlp_pkg::KIND_NET;
                if (evt.line.len >= arlp_pkg::LEN_NET_DIG && arlp_pkg::is_digit(net_chr))
                    net_next = net_chr[3:0];
            end
        end
    end

    always_comb
    begin
        rsp_next                = rsp_reg;
        rsp_next.line_kind      = kind;
        rsp_next.sim_now        = sim_next;
        rsp_next.net_now        = net_next;
        rsp_next.signal_now     = sig_next;
        rsp_next.sim_removed    = removed;
        rsp_next.signal_report  = report;
        valid_next = valid_reg;
        if (evt.fire)
            valid_next = 1'b1;
        else if (out_ready)
            valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sim_reg   <= 4'd0;
            net_reg   <= 4'd0;
            sig_reg   <= 8'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            sim_reg   <= sim_next;
            net_reg   <= net_next;
            sig_reg   <= sig_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt.fire)
            rsp_reg <= rsp_next;
    end

    assign out_valid = valid_reg;
    assign rsp       = rsp_reg;

endmodule

[rtl/at_response_line_parser.sv]
// Top level of the AT response line parser.
//
// Takes one modem byte per request on rx and splits the stream into lines at
// each CR immediately followed by LF; a CR not followed by LF is content.
// Lines of fewer than two characters are dropped silently. Every other line
// gives one request on rsp: the line kind (other, +QSIMSTAT, +CSQ,
// +QNETDEVSTATUS), the stored sim, net and signal states after the line, a
// sim-removed flag (sim state just went to zero) and a signal-report flag
// (a +CSQ line carried a number). Only the first 128 characters of a line are
// kept; the rest is dropped but the line still ends at CR LF. Rate: one byte
// per clock while rx does not stall. A byte that ends a line is loaded into
// the input register when it is taken, and its result then into the result
// register that drives rsp. rx stalls only while a result waits on rsp and
// the registered byte cannot move forward.
module at_response_line_parser (
    input  logic        clk,
    input  logic        rst_n,
    arlp_in_if.sink     rx,
    arlp_out_if.source  rsp
);

    arlp_pkg::line_evt_t evt;
    arlp_pkg::rsp_t      result;
    logic                advance;

    // Registered byte may be processed when the result register is free or
    // being emptied this cycle.
    assign advance = !rsp.valid || rsp.ready;

    arlp_line_split u_split (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (rx.valid),
        .in_byte  (rx.rx_byte),
        .in_ready (rx.ready),
        .advance  (advance),
        .evt      (evt)
    );

    arlp_line_decode u_decode (
        .clk       (clk),
        .rst_n     (rst_n),
        .evt       (evt),
        .out_ready (rsp.ready),
        .out_valid (rsp.valid),
        .rsp       (result)
    );

    assign rsp.line_kind     = result.line_kind;
    assign rsp.sim_now       = result.sim_now;
    assign rsp.net_now       = result.net_now;
    assign rsp.signal_now    = result.signal_now;
    assign rsp.sim_removed   = result.sim_removed;
    assign rsp.signal_report = result.signal_report;

endmodule
